>>> hw/rtl/hsl_to_rgb_converter_defines.svh
// Assertion macros shared by the HSL to RGB converter RTL.
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside reset.
`define HSL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define HSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define HSL_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/hsl2rgb_pkg.sv
// Shared types, constants and the hue ramp function of the HSL to RGB converter.
`timescale 1ns / 1ps
package hsl2rgb_pkg;

    // Field widths that do not vary.
    localparam int HUE_BITS   = 16;
    localparam int ALPHA_BITS = 8;
    localparam int FRAC_BITS  = HUE_BITS + 1;

    // One third of a turn in Q0.16.
    localparam logic [HUE_BITS-1:0] HUE_THIRD = 16'h5555;

    // Pipeline layout: stage numbers of the register stages.
    localparam int PIPE_STAGES = 7;
    localparam int ST_IN       = 0;
    localparam int ST_BOUND    = 4;
    localparam int ST_MUL      = 5;
    localparam int ST_LAST     = PIPE_STAGES - 1;

    // Per-stage load enables and valid bits.
    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic [PIPE_STAGES-1:0] valid;
    } t_pipe_ctrl;

    // Hue ramp weight in 0..65536 for a wrapped hue: rising, top, falling, bottom.
    function automatic logic [FRAC_BITS-1:0] hsl_ramp_frac(input logic [HUE_BITS-1:0] h);
        logic [HUE_BITS+2:0] six;
        logic [HUE_BITS+2:0] fall;
        logic [FRAC_BITS-1:0] f;
        six  = {h, 2'b00} + {1'b0, h, 1'b0};
        fall = 19'h40000 - six;
        if (six < 19'h10000) begin
            f = six[FRAC_BITS-1:0];
        end else if (six < 19'h30000) begin
            f = 17'h10000;
        end else if (six < 19'h40000) begin
            f = fall[FRAC_BITS-1:0];
        end else begin
            f = '0;
        end
        return f;
    endfunction

endpackage

>>> hw/rtl/hsl2rgb_pipe_ctrl.sv
// Valid bits and per-stage load enables of the converter pipeline.
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_defines.svh"
module hsl2rgb_pipe_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_out_ready,
    output hsl2rgb_pkg::t_pipe_ctrl o_ctrl
);
    import hsl2rgb_pkg::*;

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] w_en;

    // A stage loads when it is empty or its item moves on this cycle.
    always_comb begin
        w_en[ST_LAST] = !r_valid[ST_LAST] || i_out_ready;
        for (int k = ST_LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    // Valid bits follow the items down the stages.
    always_comb begin
        n_valid = r_valid;
        if (w_en[ST_IN]) begin
            n_valid[ST_IN] = i_in_valid;
        end
        for (int k = ST_IN + 1; k < PIPE_STAGES; k++) begin
            if (w_en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready   = w_en[ST_IN];
    assign o_ctrl.en    = w_en;
    assign o_ctrl.valid = r_valid;

    `HSL_ASSERT(a_accept_fills, i_clk, i_rst_n, (i_in_valid && w_en[ST_IN]) |=> r_valid[ST_IN], "accepted item did not enter the first stage")
    `HSL_ASSERT(a_result_held, i_clk, i_rst_n, (r_valid[ST_LAST] && !i_out_ready) |=> r_valid[ST_LAST], "result dropped while stalled")
    `HSL_ASSERT_IMPL(a_flow_through, i_clk, i_rst_n, i_out_ready, o_in_ready, "input stalled while output drains")
endmodule

>>> hw/rtl/hsl2rgb_bounds.sv
// Lower bound m1 and span m2 - m1 from lightness and saturation, five stages.
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_defines.svh"
module hsl2rgb_bounds #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hsl2rgb_pkg::t_pipe_ctrl i_ctrl,
    input  logic [CHANNEL_BITS-1:0] i_saturation,
    input  logic [CHANNEL_BITS-1:0] i_lightness,
    output logic [CHANNEL_BITS-1:0] o_m1,
    output logic [CHANNEL_BITS-1:0] o_span
);
    import hsl2rgb_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};
    localparam logic [CB-1:0] HALF = FULL >> 1;

    // Stage 0: raw product l*s.
    logic [CB-1:0]   r_l0, r_s0;
    logic [2*CB-1:0] r_ls0;
    // Stage 1: product rounded to a channel value.
    logic [CB-1:0]   r_l1, r_s1, r_prod1;
    // Stage 2: upper bound.
    logic [CB-1:0]   r_l2, r_m2_2;
    // Stage 3: lower bound.
    logic [CB-1:0]   r_m1_3, r_m2_3;
    // Stage 4: lower bound and span.
    logic [CB-1:0]   r_m1_4, r_d4;

    logic [2*CB:0]   w_y;
    logic [2*CB:0]   w_qsum;
    logic [CB+1:0]   w_m2s;
    logic [CB+1:0]   w_m1s;
    logic [CB-1:0]   w_m2;
    logic [CB-1:0]   w_m1;

    // Divide by FULL with rounding: y = p + FULL/2, q = (y + (y >> CB) + 1) >> CB.
    always_comb begin
        w_y    = {1'b0, r_ls0} + {{(CB+1){1'b0}}, HALF};
        w_qsum = w_y + (w_y >> CB) + {{(2*CB){1'b0}}, 1'b1};
    end

    // Upper bound: l*(1+s) for dark pixels, l+s-l*s for light ones, clamped.
    always_comb begin
        if (!r_l1[CB-1]) begin
            w_m2s = {2'b00, r_l1} + {2'b00, r_prod1};
        end else begin
            w_m2s = {2'b00, r_l1} + {2'b00, r_s1} - {2'b00, r_prod1};
        end
        if (w_m2s[CB+1]) begin
            w_m2 = '0;
        end else if (w_m2s[CB]) begin
            w_m2 = FULL;
        end else begin
            w_m2 = w_m2s[CB-1:0];
        end
    end

    // Lower bound: 2*l - m2, clamped.
    always_comb begin
        w_m1s = {1'b0, r_l2, 1'b0} - {2'b00, r_m2_2};
        if (w_m1s[CB+1]) begin
            w_m1 = '0;
        end else if (w_m1s[CB]) begin
            w_m1 = FULL;
        end else begin
            w_m1 = w_m1s[CB-1:0];
        end
    end

    // Stage registers, each loading on its own enable.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_l0  <= i_lightness;
            r_s0  <= i_saturation;
            r_ls0 <= i_lightness * i_saturation;
        end
        if (i_ctrl.en[1]) begin
            r_l1    <= r_l0;
            r_s1    <= r_s0;
            r_prod1 <= w_qsum[2*CB-1:CB];
        end
        if (i_ctrl.en[2]) begin
            r_l2   <= r_l1;
            r_m2_2 <= w_m2;
        end
        if (i_ctrl.en[3]) begin
            r_m1_3 <= w_m1;
            r_m2_3 <= r_m2_2;
        end
        if (i_ctrl.en[ST_BOUND]) begin
            r_m1_4 <= r_m1_3;
            r_d4   <= (r_m2_3 >= r_m1_3) ? (r_m2_3 - r_m1_3) : '0;
        end
    end

    assign o_m1   = r_m1_4;
    assign o_span = r_d4;

    `HSL_ASSERT_IMPL(a_prod_le_sat, i_clk, i_rst_n, i_ctrl.valid[1], (r_prod1 <= r_s1), "rounded l*s exceeds s")
    `HSL_ASSERT_IMPL(a_bounds_order, i_clk, i_rst_n, i_ctrl.valid[3], (r_m1_3 <= r_m2_3), "lower bound above upper bound")
    `HSL_ASSERT_IMPL(a_span_fits, i_clk, i_rst_n, i_ctrl.valid[ST_BOUND], (({1'b0, r_d4} + {1'b0, r_m1_4}) <= {1'b0, FULL}), "m1 plus span exceeds full scale")
endmodule

>>> hw/rtl/hsl2rgb_lane.sv
// One color channel: hue ramp weight, span multiply, rounding and clamp.
`timescale 1ns / 1ps
module hsl2rgb_lane #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                              i_clk,
    input  hsl2rgb_pkg::t_pipe_ctrl           i_ctrl,
    input  logic [hsl2rgb_pkg::HUE_BITS-1:0]  i_hue,
    input  logic [CHANNEL_BITS-1:0]           i_m1,
    input  logic [CHANNEL_BITS-1:0]           i_span,
    output logic [CHANNEL_BITS-1:0]           o_chan
);
    import hsl2rgb_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int MW = CB + FRAC_BITS;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    logic [FRAC_BITS-1:0] r_f [0:ST_BOUND];
    logic [MW-1:0]        r_mul;
    logic [CB-1:0]        r_m1;
    logic [CB-1:0]        r_chan;

    logic [MW-1:0]        w_rnd;
    logic [CB+1:0]        w_sum;

    // Weight is formed at entry and travels alongside the bound stages.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[ST_IN]) begin
            r_f[0] <= hsl_ramp_frac(i_hue);
        end
        for (int k = 1; k <= ST_BOUND; k++) begin
            if (i_ctrl.en[k]) begin
                r_f[k] <= r_f[k-1];
            end
        end
    end

    // Round the product half up, add the lower bound and clamp.
    always_comb begin
        w_rnd = r_mul + MW'(1 << (HUE_BITS - 1));
        w_sum = {2'b00, r_m1} + {1'b0, w_rnd[MW-1:HUE_BITS]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[ST_MUL]) begin
            r_mul <= i_span * r_f[ST_BOUND];
            r_m1  <= i_m1;
        end
        if (i_ctrl.en[ST_LAST]) begin
            r_chan <= (w_sum > {2'b00, FULL}) ? FULL : w_sum[CB-1:0];
        end
    end

    assign o_chan = r_chan;
endmodule

>>> hw/rtl/hsl_to_rgb_converter.sv
// Top level of the pipelined HSL to RGB pixel converter.
//
//  channel  dir  group                      tdata fields, lowest bit first
//  pixel    in   i_s_axis_* / o_s_axis_*    hue, saturation, lightness, alpha_in
//  color    out  o_m_axis_* / i_m_axis_*    red, green, blue, alpha_out
//
// One item per clock is accepted while the output takes results; each item
// spends seven register stages in the pipeline (multiply l*s, divide by full
// scale, two bound stages, span, span times ramp weight, round and clamp).
// Reset clears only the stage valid bits; data registers are left as they are.
// A stalled output holds its item; stages behind it keep filling bubbles, and
// the input stalls only once every stage holds an item.
`timescale 1ns / 1ps
module hsl_to_rgb_converter #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Pixel item: hue, saturation, lightness, alpha_in, zero padded to bytes.
    input  logic [((hsl2rgb_pkg::HUE_BITS + 2*CHANNEL_BITS + hsl2rgb_pkg::ALPHA_BITS + 7) / 8)
                  * 8 - 1:0] i_s_axis_tdata,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // Color item: red, green, blue, alpha_out, zero padded to bytes.
    output logic [((3*CHANNEL_BITS + hsl2rgb_pkg::ALPHA_BITS + 7) / 8) * 8 - 1:0]
                 o_m_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready
);
    import hsl2rgb_pkg::*;

    localparam int CB         = CHANNEL_BITS;
    localparam int OUT_W      = 3*CB + ALPHA_BITS;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int SAT_LO     = HUE_BITS;
    localparam int LIGHT_LO   = HUE_BITS + CB;
    localparam int ALPHA_LO   = HUE_BITS + 2*CB;

    t_pipe_ctrl w_ctrl;

    logic [HUE_BITS-1:0]   w_hue;
    logic [HUE_BITS-1:0]   w_hue_r;
    logic [HUE_BITS-1:0]   w_hue_b;
    logic [CB-1:0]         w_sat;
    logic [CB-1:0]         w_light;
    logic [ALPHA_BITS-1:0] w_alpha;
    logic [CB-1:0]         w_m1;
    logic [CB-1:0]         w_span;
    logic [CB-1:0]         w_red;
    logic [CB-1:0]         w_green;
    logic [CB-1:0]         w_blue;
    logic [ALPHA_BITS-1:0] r_alpha [0:ST_LAST];

    // Unpack the input item; red and blue read the hue a third of a turn apart.
    assign w_hue   = i_s_axis_tdata[HUE_BITS-1:0];
    assign w_sat   = i_s_axis_tdata[SAT_LO +: CB];
    assign w_light = i_s_axis_tdata[LIGHT_LO +: CB];
    assign w_alpha = i_s_axis_tdata[ALPHA_LO +: ALPHA_BITS];
    assign w_hue_r = w_hue + HUE_THIRD;
    assign w_hue_b = w_hue - HUE_THIRD;

    hsl2rgb_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_ctrl      (w_ctrl)
    );

    hsl2rgb_bounds #(.CHANNEL_BITS(CB)) u_bounds (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_saturation (w_sat),
        .i_lightness  (w_light),
        .o_m1         (w_m1),
        .o_span       (w_span)
    );

    hsl2rgb_lane #(.CHANNEL_BITS(CB)) u_red (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_hue  (w_hue_r),
        .i_m1   (w_m1),
        .i_span (w_span),
        .o_chan (w_red)
    );

    hsl2rgb_lane #(.CHANNEL_BITS(CB)) u_green (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_hue  (w_hue),
        .i_m1   (w_m1),
        .i_span (w_span),
        .o_chan (w_green)
    );

    hsl2rgb_lane #(.CHANNEL_BITS(CB)) u_blue (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_hue  (w_hue_b),
        .i_m1   (w_m1),
        .i_span (w_span),
        .o_chan (w_blue)
    );

    // Alpha rides a delay line matched to the color stages.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[ST_IN]) begin
            r_alpha[ST_IN] <= w_alpha;
        end
        for (int k = ST_IN + 1; k < PIPE_STAGES; k++) begin
            if (w_ctrl.en[k]) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    // Pack the result item.
    assign o_m_axis_tdata  = OUT_DATA_W'({r_alpha[ST_LAST], w_blue, w_green, w_red});
    assign o_m_axis_tvalid = w_ctrl.valid[ST_LAST];
endmodule

>>> tb/sv/testbench.sv
// Self-checking stream testbench for the HSL to RGB pixel converter.
`timescale 1ns / 1ps
module testbench;
    import hsl2rgb_pkg::*;

    localparam int CH_BITS    = 16;
    localparam int PIX_W      = ((HUE_BITS + 2*CH_BITS + ALPHA_BITS + 7) / 8) * 8;
    localparam int COLOR_W    = ((3*CH_BITS + ALPHA_BITS + 7) / 8) * 8;
    localparam longint FULL   = (64'd1 << CH_BITS) - 1;
    localparam int RAND_ITEMS = 1500;
    localparam int CALM_ITEMS = 200;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 80;
    localparam int PIPE_WAIT  = 20;
    localparam int N_DIR      = 22;

    // One pixel with an optional hand-worked color.
    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] light;
        logic [7:0]  alpha;
        logic        known;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_pixel_row;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [7:0]  alpha;
    } t_color;

    logic               i_clk;
    logic               i_rst_n;
    logic [PIX_W-1:0]   i_s_axis_tdata;   // hue, saturation, lightness, alpha_in
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [COLOR_W-1:0] o_m_axis_tdata;   // red, green, blue, alpha_out
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;

    t_color color_q[$];
    int     mismatches;
    int     pixels_sent;
    bit     calm;

    // Directed pixels: extremes, half lightness, and hue sector edges.
    t_pixel_row dir_rows [0:N_DIR-1] = '{
        '{16'd0,     16'd0,     16'd0,     8'd0,   1'b1, 16'd0,     16'd0,     16'd0},
        '{16'd65535, 16'd0,     16'd65535, 8'd255, 1'b1, 16'd65535, 16'd65535, 16'd65535},
        '{16'd0,     16'd65535, 16'd65535, 8'h5a,  1'b1, 16'd65535, 16'd65535, 16'd65535},
        '{16'h1234,  16'd65535, 16'd0,     8'ha5,  1'b1, 16'd0,     16'd0,     16'd0},
        '{16'd0,     16'd0,     16'd32767, 8'd1,   1'b1, 16'd32767, 16'd32767, 16'd32767},
        '{16'd0,     16'd65535, 16'd32767, 8'd255, 1'b1, 16'd65534, 16'd0,     16'd0},
        '{16'd0,     16'd65535, 16'd32768, 8'd128, 1'b1, 16'd65535, 16'd1,     16'd1},
        '{16'd10922, 16'd65535, 16'd32767, 8'd2,   1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd10923, 16'd65535, 16'd32767, 8'd4,   1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd21845, 16'd65535, 16'd32768, 8'd8,   1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd32767, 16'd40000, 16'd20000, 8'd16,  1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd32768, 16'd40000, 16'd20000, 8'd32,  1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd43690, 16'd65535, 16'd45000, 8'd64,  1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd43691, 16'd65535, 16'd45000, 8'd127, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd54613, 16'd32768, 16'd16384, 8'd254, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd65535, 16'd65535, 16'd32767, 8'd170, 1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd1,     16'd1,     16'd1,     8'd85,  1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd5000,  16'd65535, 16'd1,     8'd3,   1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd60000, 16'd65535, 16'd65534, 8'd7,   1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd30000, 16'd1,     16'd65534, 8'd9,   1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd15000, 16'd32768, 16'd32768, 8'd11,  1'b0, 16'd0, 16'd0, 16'd0},
        '{16'd50000, 16'd12345, 16'd54321, 8'd13,  1'b0, 16'd0, 16'd0, 16'd0}
    };

    hsl_to_rgb_converter #(
        .CHANNEL_BITS(CH_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Limits a signed bound to the channel range.
    function automatic longint clamp_channel(input longint v);
        if (v < 0) begin
            return 0;
        end else if (v > FULL) begin
            return FULL;
        end
        return v;
    endfunction

    // One channel read off the piecewise-linear hue ramp between the bounds.
    function automatic logic [15:0] hue_ramp_level(input logic [15:0] h, input longint lo,
                                                  input longint hi);
        longint six;
        longint span;
        longint weight;
        longint level;
        six  = longint'(h) * 6;
        span = (hi >= lo) ? hi - lo : 0;
        if (six < 64'h10000) begin
            weight = six;
        end else if (six < 64'h30000) begin
            weight = 64'h10000;
        end else if (six < 64'h40000) begin
            weight = 64'h40000 - six;
        end else begin
            weight = 0;
        end
        level = lo + ((span * weight + 64'h8000) >>> 16);
        if (level > FULL) begin
            level = FULL;
        end
        return level[15:0];
    endfunction

    // Expected color for one pixel.
    function automatic t_color hsl_to_color(input t_pixel_row p);
        longint s;
        longint l;
        longint prod;
        longint hi;
        longint lo;
        t_color c;
        s    = longint'(p.sat);
        l    = longint'(p.light);
        prod = (l * s + (FULL >> 1)) / FULL;
        // Half lightness rounded down still uses the lower formula.
        if (2 * l <= FULL) begin
            hi = clamp_channel(l + prod);
        end else begin
            hi = clamp_channel(l + s - prod);
        end
        lo = clamp_channel(2 * l - hi);
        c.red   = hue_ramp_level(p.hue + HUE_THIRD, lo, hi);
        c.green = hue_ramp_level(p.hue, lo, hi);
        c.blue  = hue_ramp_level(p.hue - HUE_THIRD, lo, hi);
        c.alpha = p.alpha;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Offers one pixel, with an occasional idle burst ahead of it.
    task automatic send_pixel(input t_pixel_row p, input bit may_idle);
        t_color want;
        if (may_idle && !calm && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_s_axis_tdata  = {p.alpha, p.light, p.sat, p.hue};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (p.known) begin
            want.red   = p.red;
            want.green = p.green;
            want.blue  = p.blue;
            want.alpha = p.alpha;
        end else begin
            want = hsl_to_color(p);
        end
        color_q.push_back(want);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Picks a channel value, leaning toward the edges and the midpoint now and then.
    function automatic logic [15:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd65535;
            2: return 16'd32767 + 16'($urandom_range(0, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    // Reset and pixel source.
    initial begin
        t_pixel_row p;
        bit         may_idle;
        mismatches      = 0;
        pixels_sent     = 0;
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send_pixel(dir_rows[i], 1'b1);
        end

        // Random pixels, in stretches with and without source gaps.
        may_idle = 1'b1;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 100 == 0) begin
                may_idle = ($urandom_range(0, 2) != 0);
            end
            calm    = (i >= RAND_ITEMS - CALM_ITEMS);
            p.hue   = 16'($urandom);
            p.sat   = pick_channel();
            p.light = pick_channel();
            p.alpha = 8'($urandom);
            p.known = 1'b0;
            p.red   = '0;
            p.green = '0;
            p.blue  = '0;
            send_pixel(p, may_idle);
        end
        i_s_axis_tvalid = 1'b0;

        // Drain the pipeline, then let it settle.
        for (int i = 0; i < 10000 && color_q.size() != 0; i++) begin
            @(posedge i_clk);
        end
        repeat (PIPE_WAIT) @(posedge i_clk);
        if (color_q.size() != 0) begin
            report_mismatch("colors never delivered", color_q.size(), 0);
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Color sink: random stalls, one long hold-off, none near the end.
    initial begin
        bit held;
        held            = 1'b0;
        i_m_axis_tready = 1'b1;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && pixels_sent >= HOLD_AT) begin
                held            = 1'b1;
                i_m_axis_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                i_m_axis_tready = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // Compare each delivered color with the oldest expected one.
    always @(posedge i_clk) begin : check_color
        t_color want;
        t_color got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.red   = o_m_axis_tdata[15:0];
            got.green = o_m_axis_tdata[31:16];
            got.blue  = o_m_axis_tdata[47:32];
            got.alpha = o_m_axis_tdata[55:48];
            if (color_q.size() == 0) begin
                report_mismatch("unexpected color item, red", got.red, 0);
            end else begin
                want = color_q.pop_front();
                if (got.red !== want.red) begin
                    report_mismatch("red", got.red, want.red);
                end
                if (got.green !== want.green) begin
                    report_mismatch("green", got.green, want.green);
                end
                if (got.blue !== want.blue) begin
                    report_mismatch("blue", got.blue, want.blue);
                end
                if (got.alpha !== want.alpha) begin
                    report_mismatch("alpha", got.alpha, want.alpha);
                end
            end
        end
    end

endmodule
